[rtl/urla_pkg.sv]
package urla_pkg;

  // line store geometry
  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH);

  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] TERM_AT  = CNT_W'(DEPTH - 2);

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] NUL_CODE     = 8'h00;

  // request codes carried in the action field
  localparam logic ACT_RX   = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT,
    ST_TERM
  } state_t;

  // result load request from the sequencer to the output register
  typedef struct packed {
    logic load;
    logic line_ready;
    logic data_valid;
    logic from_mem;
    logic last;
  } res_t;

endpackage

[rtl/urla_if.sv]
interface urla_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  logic [7:0] dest_size;

  modport source (output valid, action, rx_byte, dest_size, input ready);
  modport sink   (input valid, action, rx_byte, dest_size, output ready);
endinterface

interface urla_out_if;
  logic       valid;
  logic       ready;
  logic       line_ready;
  logic       data_valid;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, line_ready, data_valid, out_byte, last, input ready);
  modport sink   (input valid, line_ready, data_valid, out_byte, last, output ready);
endinterface

[rtl/urla_store.sv]
module urla_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [urla_pkg::CNT_W-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic                       re,
  input  logic [urla_pkg::CNT_W-1:0] raddr,
  output logic [7:0]                 rdata
);

  logic [7:0] mem [urla_pkg::DEPTH];
  logic [7:0] rdata_r;

  // write one byte, read one byte with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/urla_seq.sv]
module urla_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [7:0]                 in_rx_byte,
  input  logic [7:0]                 in_dest_size,
  input  logic                       out_free,
  output urla_pkg::res_t             res,
  output logic                       we,
  output logic [urla_pkg::CNT_W-1:0] waddr,
  output logic [7:0]                 wdata,
  output logic                       re,
  output logic [urla_pkg::CNT_W-1:0] raddr
);

  urla_pkg::state_t           state_r, state_nxt;
  logic [urla_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic                       pending_r, pending_nxt;
  logic [urla_pkg::CNT_W-1:0] addr_r, addr_nxt;
  logic [urla_pkg::CNT_W-1:0] rem_r, rem_nxt;

  logic                       accept;
  logic                       term;
  logic [8:0]                 len_ext;
  logic [8:0]                 lim_ext;
  logic [urla_pkg::CNT_W-1:0] n_bytes;

  assign accept = in_valid && in_ready;

  // terminate on zero, newline or the last free slot
  assign term = (in_rx_byte == urla_pkg::NUL_CODE) ||
                (in_rx_byte == urla_pkg::NEWLINE_CODE) ||
                (fill_r == urla_pkg::TERM_AT);

  // characters to copy: min(fill - 1, dest_size - 1)
  assign len_ext = 9'(fill_r - urla_pkg::CNT_W'(1));
  assign lim_ext = {1'b0, in_dest_size} - 9'd1;
  assign n_bytes = (len_ext < lim_ext) ? urla_pkg::CNT_W'(len_ext)
                                       : urla_pkg::CNT_W'(lim_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= urla_pkg::ST_IDLE;
      fill_r    <= '0;
      pending_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    rem_r  <= rem_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    pending_nxt = pending_r;
    addr_nxt    = addr_r;
    rem_nxt     = rem_r;
    in_ready    = 1'b0;
    res         = '0;
    we          = 1'b0;
    waddr       = fill_r;
    wdata       = term ? urla_pkg::NUL_CODE : in_rx_byte;
    re          = 1'b0;
    raddr       = addr_r;

    unique case (state_r)
      urla_pkg::ST_IDLE: begin
        in_ready = out_free;
        if (accept) begin
          if (in_action == urla_pkg::ACT_RX) begin
            // store the byte unless a line waits or the store is full
            if (!pending_r && (fill_r < urla_pkg::FILL_MAX)) begin
              we          = 1'b1;
              fill_nxt    = fill_r + urla_pkg::CNT_W'(1);
              pending_nxt = term;
            end
          end else if (!pending_r) begin
            res.load = 1'b1;
            res.last = 1'b1;
          end else if (in_dest_size == 8'd0) begin
            // drop the line and report an empty delivery
            res.load       = 1'b1;
            res.line_ready = 1'b1;
            res.last       = 1'b1;
            fill_nxt       = '0;
            pending_nxt    = 1'b0;
          end else begin
            addr_nxt  = '0;
            rem_nxt   = n_bytes;
            state_nxt = (n_bytes == '0) ? urla_pkg::ST_TERM : urla_pkg::ST_FETCH;
          end
        end
      end
      urla_pkg::ST_FETCH: begin
        re        = 1'b1;
        state_nxt = urla_pkg::ST_EMIT;
      end
      urla_pkg::ST_EMIT: begin
        // hand the fetched byte over and advance the index
        if (out_free) begin
          res.load       = 1'b1;
          res.line_ready = 1'b1;
          res.data_valid = 1'b1;
          res.from_mem   = 1'b1;
          addr_nxt       = addr_r + urla_pkg::CNT_W'(1);
          rem_nxt        = rem_r - urla_pkg::CNT_W'(1);
          state_nxt      = (rem_r == urla_pkg::CNT_W'(1)) ? urla_pkg::ST_TERM
                                                          : urla_pkg::ST_FETCH;
        end
      end
      urla_pkg::ST_TERM: begin
        // send the terminator and clear the fill count and the pending mark
        if (out_free) begin
          res.load       = 1'b1;
          res.line_ready = 1'b1;
          res.data_valid = 1'b1;
          res.last       = 1'b1;
          fill_nxt       = '0;
          pending_nxt    = 1'b0;
          state_nxt      = urla_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = urla_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/uart_rx_line_assembler.sv]
// Channel | Dir | Payload                                   | Handshake
// in_if   | in  | action, rx_byte[7:0], dest_size[7:0]      | valid/ready
// out_if  | out | line_ready, data_valid, out_byte[7:0], last | valid/ready
//
// A received byte is stored when accepted unless a line is pending or the
// store is full. A read that delivers a line passes each character through
// the registered store read port into the output register, then the
// terminator; a read with no line pending, or dest_size zero, loads one word.
// Reset clears the fill count, the pending mark and the sequencer; the store
// is not cleared. Output stalls hold the sequencer; input is taken only when
// the sequencer is idle and the output register is free or being drained.
module uart_rx_line_assembler (
  input  logic            clk,
  input  logic            rst_n,
  urla_in_if.sink         in_if,
  urla_out_if.source      out_if
);

  urla_pkg::res_t             res;
  logic                       out_free;
  logic                       we;
  logic [urla_pkg::CNT_W-1:0] waddr;
  logic [7:0]                 wdata;
  logic                       re;
  logic [urla_pkg::CNT_W-1:0] raddr;
  logic [7:0]                 rdata;

  logic       out_valid_r, out_valid_nxt;
  logic       line_ready_r;
  logic       data_valid_r;
  logic [7:0] out_byte_r;
  logic       last_r;

  assign out_free = !out_valid_r || out_if.ready;

  urla_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .in_action    (in_if.action),
    .in_rx_byte   (in_if.rx_byte),
    .in_dest_size (in_if.dest_size),
    .out_free     (out_free),
    .res          (res),
    .we           (we),
    .waddr        (waddr),
    .wdata        (wdata),
    .re           (re),
    .raddr        (raddr)
  );

  urla_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // hold the word until taken, load a new one when requested
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      line_ready_r <= res.line_ready;
      data_valid_r <= res.data_valid;
      out_byte_r   <= res.from_mem ? rdata : urla_pkg::NUL_CODE;
      last_r       <= res.last;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.line_ready = line_ready_r;
  assign out_if.data_valid = data_valid_r;
  assign out_if.out_byte   = out_byte_r;
  assign out_if.last       = last_r;

endmodule
